[rtl/rqr_pkg.sv]
// ----------------------------------------------------------------------------
// rqr_pkg
// Shared types and codes of the ready queue with removal.
// ----------------------------------------------------------------------------
`default_nettype none

package rqr_pkg;

  localparam int unsigned KIND_W      = 2;
  localparam int unsigned TASK_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [TASK_W-1:0]      head_task;
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

[rtl/rqr_in_if.sv]
// ----------------------------------------------------------------------------
// rqr_in_if
// Operation channel: valid/ready handshake with kind and task number.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqr_in_if;
  logic                       valid;
  logic                       ready;
  logic [rqr_pkg::KIND_W-1:0] kind;
  logic [rqr_pkg::TASK_W-1:0] task_id;

  modport source (output valid, output kind, output task_id, input ready);
  modport sink   (input valid, input kind, input task_id, output ready);
endinterface

`default_nettype wire

[rtl/rqr_out_if.sv]
// ----------------------------------------------------------------------------
// rqr_out_if
// Result channel: valid/ready handshake with head task, status and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqr_out_if;
  logic                            valid;
  logic                            ready;
  logic [rqr_pkg::TASK_W-1:0]      head_task;
  logic [rqr_pkg::STATUS_W-1:0]    status;
  logic [rqr_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output head_task, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input head_task, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/ready_queue_with_removal_top.sv]
// ----------------------------------------------------------------------------
// ready_queue_with_removal_top
// Ordered task queue with push, pop head and remove by value.
//
// Channels: in_i takes one operation beat (kind, task_id); out_o returns one
// result beat (head_task, status, entry_count) for every operation, in order.
// Pipeline: an input register and a result register bracket the queue update
// logic, and the result beat is driven from the result register.
// Throughput: one operation per cycle unless out_o stalls; the queue entries
// are compared and shifted in parallel.
// Reset: the queue is emptied; pending beats in both registers are dropped.
// Stall: a held result keeps its register; the input register then fills and
// in_i.ready falls until out_o.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_with_removal_top #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rqr_in_if.sink    in_i,
  rqr_out_if.source out_o
);
  import rqr_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic              s1_valid_q;
  logic [KIND_W-1:0] s1_kind_q;
  logic [TASK_W-1:0] s1_task_q;
  logic              s1_adv;
  logic              in_fire;

  logic              out_valid_q;
  res_t              res_q;
  res_t              res_d;

  logic [TASK_W-1:0] entries_q [QUEUE_DEPTH];
  logic [TASK_W-1:0] entries_d [QUEUE_DEPTH];
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_d;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] shift_mask;
  logic                   found;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_match
    assign match[g]      = (CW'(g) < count_q) && (entries_q[g] == s1_task_q);
    assign shift_mask[g] = |match[g:0];
  end

  assign found = |match;

  always_comb begin
    entries_d         = entries_q;
    count_d           = count_q;
    res_d.head_task   = '0;
    res_d.status      = ST_OK;
    case (kind_e'(s1_kind_q))
      KIND_PUSH: begin
        if (count_q == CW'(QUEUE_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          entries_d[count_q[AW-1:0]] = s1_task_q;
          count_d = count_q + 1'b1;
        end
      end
      KIND_POP: begin
        if (count_q == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.head_task = entries_q[0];
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            entries_d[k] = entries_q[k+1];
          end
          count_d = count_q - 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!found) begin
          res_d.status = ST_NOT_FOUND;
        end else begin
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (shift_mask[k]) begin
              entries_d[k] = entries_q[k+1];
            end
          end
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    res_d.entry_count = COUNT_OUT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_i.kind;
      s1_task_q <= in_i.task_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      entries_q <= entries_d;
      res_q     <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.head_task   = res_q.head_task;
  assign out_o.status      = res_q.status;
  assign out_o.entry_count = res_q.entry_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_empty_only_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (res_d.status == ST_EMPTY) |-> count_q == '0)
    else $error("empty status with entries held");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result register not loaded");

  a_pop_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_kind_q == KIND_POP) && (count_q != '0)
    |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not drop one entry");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ready queue with removal.
//
// Drives push, pop and remove beats into in_i with random gaps and collects
// result beats from out_o under random backpressure. A scoreboard keeps its
// own copy of the task queue, predicts head task, status and count for every
// accepted beat and compares each result beat against the oldest prediction.
// A directed opening covers empty, full, duplicate and unused-kind cases;
// the random part sweeps the queue between empty and full.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rqr_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 8;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int unsigned RANDOM_OPS   = 630;
  localparam int unsigned DRAIN_CYCLES = 10;

  class rqr_scoreboard;
    logic [TASK_W-1:0] model_tasks[$];
    res_t              expected_results[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    function void note_op(logic [KIND_W-1:0] kind, logic [TASK_W-1:0] id);
      res_t r;
      bit   found;
      r.head_task = '0;
      r.status    = ST_OK;
      found       = 1'b0;
      if (kind == KIND_PUSH) begin
        if (model_tasks.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else model_tasks.push_back(id);
      end else if (kind == KIND_POP) begin
        if (model_tasks.size() == 0) r.status = ST_EMPTY;
        else r.head_task = model_tasks.pop_front();
      end else if (kind == KIND_REMOVE) begin
        for (int k = 0; k < model_tasks.size() && !found; k++) begin
          if (model_tasks[k] == id) begin
            model_tasks.delete(k);
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      r.entry_count = COUNT_OUT_W'(model_tasks.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [TASK_W-1:0] head, logic [STATUS_W-1:0] status,
                               logic [COUNT_OUT_W-1:0] count);
      res_t r;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: head_task %0d status %0d entry_count %0d",
               head, status, count);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (head !== r.head_task) begin
        $error("head_task: expected %0d, got %0d", r.head_task, head);
        errors++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (count !== r.entry_count) begin
        $error("entry_count: expected %0d, got %0d", r.entry_count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rqr_in_if  in_if ();
  rqr_out_if out_if ();

  rqr_scoreboard sb = new();

  ready_queue_with_removal_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [TASK_W-1:0] id,
                         input bit may_idle);
    if (may_idle && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.task_id <= id;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_op(kind, id);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  task automatic pick_op(input int unsigned n, output logic [KIND_W-1:0] kind,
                         output logic [TASK_W-1:0] id);
    int unsigned mode;
    int unsigned r;
    int unsigned push_lim;
    int unsigned pop_lim;
    mode = (n / 40) % 3;
    r    = $urandom_range(99);
    push_lim = (mode == 0) ? 55 : (mode == 1) ? 35 : 20;
    pop_lim  = (mode == 0) ? 70 : 60;
    if (r < push_lim) kind = KIND_PUSH;
    else if (r < pop_lim) kind = KIND_POP;
    else if (r < 94) kind = KIND_REMOVE;
    else kind = KIND_NOP;
    if (kind == KIND_REMOVE && sb.model_tasks.size() != 0 && $urandom_range(3) != 0) begin
      id = sb.model_tasks[$urandom_range(sb.model_tasks.size() - 1)];
    end else if ($urandom_range(1) == 1) begin
      id = TASK_W'($urandom_range(7));
    end else begin
      id = TASK_W'($urandom_range(255));
    end
  endtask

  initial begin : result_sink
    int unsigned beats;
    int unsigned hold;
    beats = 0;
    hold  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.head_task, out_if.status, out_if.entry_count);
        beats++;
        if (beats == 120) hold = 60;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (beats >= 300 && beats < 400) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  initial begin : op_source
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] id;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.kind    <= KIND_PUSH;
    in_if.task_id <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(KIND_POP, 8'd0, 1'b0);
    send_op(KIND_REMOVE, 8'd5, 1'b0);
    send_op(KIND_NOP, 8'd255, 1'b0);
    send_op(KIND_PUSH, 8'd0, 1'b0);
    send_op(KIND_PUSH, 8'd255, 1'b0);
    send_op(KIND_PUSH, 8'd0, 1'b0);
    send_op(KIND_REMOVE, 8'd0, 1'b0);
    send_op(KIND_POP, 8'd170, 1'b0);
    send_op(KIND_POP, 8'd85, 1'b0);
    send_op(KIND_POP, 8'd0, 1'b0);
    for (int k = 0; k < 8; k++) send_op(KIND_PUSH, (k % 2) ? 8'd170 : 8'd85, 1'b1);
    send_op(KIND_PUSH, 8'd1, 1'b0);
    send_op(KIND_REMOVE, 8'd254, 1'b0);
    send_op(KIND_REMOVE, 8'd170, 1'b0);
    send_op(KIND_NOP, 8'd0, 1'b0);
    send_op(KIND_POP, 8'd0, 1'b0);

    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n == 450) begin
        in_if.valid <= 1'b0;
        wait_drained();
      end
      pick_op(n, kind, id);
      send_op(kind, id, !(n >= 200 && n < 300));
    end
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : run_limit
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/rqr_pkg.sv
rtl/rqr_in_if.sv
rtl/rqr_out_if.sv
rtl/ready_queue_with_removal_top.sv
sim/tb_top.sv
